// ----- hdl/acr_pkg.sv -----
// Shared constants and types for the alternate chunk reverse unit.
package acr_pkg;

	localparam int VALUE_W = 32;
	localparam int CFG_W = 7;
	localparam int MAX_CHUNK_DEF = 64;
	localparam logic [CFG_W-1:0] CHUNK_SIZE_RESET = 7'd3;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_UP,
		CELL_DOWN
	} cell_op_t;

endpackage

// ----- hdl/acr_cell.sv -----
// One storage cell of the shift chain: holds a value or takes it from either neighbor.
module acr_cell (
	input  logic                                 clk,
	input  acr_pkg::cell_op_t                    op,
	input  logic signed [acr_pkg::VALUE_W-1:0]   from_lower,
	input  logic signed [acr_pkg::VALUE_W-1:0]   from_upper,
	output logic signed [acr_pkg::VALUE_W-1:0]   q
);

	logic signed [acr_pkg::VALUE_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (op)
			acr_pkg::CELL_UP:   data_q <= from_lower;
			acr_pkg::CELL_DOWN: data_q <= from_upper;
			default:            data_q <= data_q;
		endcase
	end

	assign q = data_q;

endmodule

// ----- hdl/alternate_chunk_reverse_unit.sv -----
// Top level of the alternate chunk reverse unit: chain of cells and its sequencer.
// The block reorders a stream of signed 32-bit values. Chunks of chunk_size values
// alternate between reversed and passed, the first chunk of a list being reversed.
// Input beats arrive on item_valid/item_stall with value and end_of_list; result
// beats leave on result_valid/result_stall with out_value and run_last, where
// run_last marks the final result caused by one input beat.
// A value of a pass chunk goes straight to the output register and appears in the
// cycle after it is taken; such beats sustain one per cycle while result_stall is low.
// A value of a reversed chunk is pushed into a row of MAX_CHUNK cells (cell 0 is
// the newest). When the chunk completes, the row shifts toward cell 0 once per
// result, so a burst of n values leaves newest first. A list that ends inside a
// reversed chunk of n held values first shifts the row toward the top cell until
// the oldest value sits there, then emits the n values oldest first from the top
// cell. No input beat is taken during a burst or a flush.
// chunk_size is written through chunk_size_we/chunk_size_wdata; zero acts as one
// and values above MAX_CHUNK act as MAX_CHUNK.
// Reset marks the chain empty, starts in the reversing phase and sets chunk_size to 3.
// While result_stall holds a beat in the output register, bursts and flushes pause
// and no input beat is taken; the shift toward the top cell before a flush goes on.
module alternate_chunk_reverse_unit #(
	parameter int MAX_CHUNK = acr_pkg::MAX_CHUNK_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 chunk_size_we,
	input  logic [acr_pkg::CFG_W-1:0]            chunk_size_wdata,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic signed [acr_pkg::VALUE_W-1:0]   value,
	input  logic                                 end_of_list,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [acr_pkg::VALUE_W-1:0]   out_value,
	output logic                                 run_last
);

	localparam int CW = $clog2(MAX_CHUNK + 1);
	localparam int WW = (CW > acr_pkg::CFG_W) ? CW : acr_pkg::CFG_W;

	typedef enum logic [1:0] {
		ST_ACCEPT,
		ST_BURST,
		ST_SKIP,
		ST_FLUSH
	} state_t;

	state_t                              state_q;
	logic [acr_pkg::CFG_W-1:0]           chunk_size_q;
	logic [CW-1:0]                       fill_q;
	logic [CW-1:0]                       pass_count_q;
	logic                                pass_phase_q;
	logic [CW-1:0]                       remain_q;
	logic [CW-1:0]                       skip_q;
	logic                                result_valid_q;
	logic signed [acr_pkg::VALUE_W-1:0]  out_value_q;
	logic                                run_last_q;

	logic signed [acr_pkg::VALUE_W-1:0]  cell_q [MAX_CHUNK];
	acr_pkg::cell_op_t                   cell_op;

	logic [WW-1:0]                       size_wide;
	logic [CW-1:0]                       eff_size;
	logic                                out_free;
	logic                                accept;
	logic                                push_ok;
	logic [CW-1:0]                       fill_inc;
	logic [CW-1:0]                       pass_inc;
	logic                                out_load;
	logic signed [acr_pkg::VALUE_W-1:0]  out_data;
	logic                                out_last;

	always_comb begin
		size_wide = WW'(chunk_size_q);
		if (chunk_size_q == '0) begin
			eff_size = CW'(1);
		end else if (size_wide > WW'(MAX_CHUNK)) begin
			eff_size = CW'(MAX_CHUNK);
		end else begin
			eff_size = CW'(size_wide);
		end
	end

	assign out_free   = !result_valid_q || !result_stall;
	assign item_stall = !((state_q == ST_ACCEPT) && out_free);
	assign accept     = item_valid && !item_stall;
	assign push_ok    = (fill_q != CW'(MAX_CHUNK));
	assign fill_inc   = push_ok ? fill_q + CW'(1) : fill_q;
	assign pass_inc   = pass_count_q + CW'(1);

	always_comb begin
		cell_op  = acr_pkg::CELL_HOLD;
		out_load = 1'b0;
		out_data = value;
		out_last = 1'b1;
		case (state_q)
			ST_ACCEPT: begin
				if (accept && !pass_phase_q && push_ok) begin
					cell_op = acr_pkg::CELL_UP;
				end
				out_load = accept && pass_phase_q;
			end
			ST_SKIP: begin
				if (skip_q != '0) begin
					cell_op = acr_pkg::CELL_UP;
				end
			end
			ST_BURST: begin
				if (out_free) begin
					cell_op = acr_pkg::CELL_DOWN;
				end
				out_load = out_free;
				out_data = cell_q[0];
				out_last = (remain_q == CW'(1));
			end
			ST_FLUSH: begin
				if (out_free) begin
					cell_op = acr_pkg::CELL_UP;
				end
				out_load = out_free;
				out_data = cell_q[MAX_CHUNK-1];
				out_last = (remain_q == CW'(1));
			end
			default: begin
				cell_op = acr_pkg::CELL_HOLD;
			end
		endcase
	end

	// Cell 0 takes new values from the input; the top cell keeps its own value on
	// a downward shift since that slot is past the end of any held chunk.
	for (genvar i = 0; i < MAX_CHUNK; i++) begin : g_chain
		logic signed [acr_pkg::VALUE_W-1:0] lower_d;
		logic signed [acr_pkg::VALUE_W-1:0] upper_d;
		if (i == 0) begin : g_first
			assign lower_d = value;
		end else begin : g_mid_lo
			assign lower_d = cell_q[i-1];
		end
		if (i == MAX_CHUNK - 1) begin : g_last
			assign upper_d = cell_q[i];
		end else begin : g_mid_hi
			assign upper_d = cell_q[i+1];
		end
		acr_cell u_cell (
			.clk        (clk),
			.op         (cell_op),
			.from_lower (lower_d),
			.from_upper (upper_d),
			.q          (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_ACCEPT;
			chunk_size_q   <= acr_pkg::CHUNK_SIZE_RESET;
			fill_q         <= '0;
			pass_count_q   <= '0;
			pass_phase_q   <= 1'b0;
			remain_q       <= '0;
			skip_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (chunk_size_we) begin
				chunk_size_q <= chunk_size_wdata;
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_ACCEPT: begin
					if (accept) begin
						if (!pass_phase_q) begin
							if (fill_inc >= eff_size) begin
								fill_q       <= '0;
								remain_q     <= fill_inc;
								pass_phase_q <= !end_of_list;
								pass_count_q <= '0;
								state_q      <= ST_BURST;
							end else if (end_of_list) begin
								fill_q   <= '0;
								remain_q <= fill_inc;
								skip_q   <= CW'(MAX_CHUNK) - fill_inc;
								state_q  <= ST_SKIP;
							end else begin
								fill_q <= fill_inc;
							end
						end else if (end_of_list || pass_inc >= eff_size) begin
							pass_phase_q <= 1'b0;
							pass_count_q <= '0;
						end else begin
							pass_count_q <= pass_inc;
						end
					end
				end
				ST_SKIP: begin
					if (skip_q == '0) begin
						state_q <= ST_FLUSH;
					end else begin
						skip_q <= skip_q - CW'(1);
					end
				end
				ST_BURST, ST_FLUSH: begin
					if (out_free) begin
						remain_q <= remain_q - CW'(1);
						if (remain_q == CW'(1)) begin
							state_q <= ST_ACCEPT;
						end
					end
				end
				default: begin
					state_q <= ST_ACCEPT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= out_data;
			run_last_q  <= out_last;
		end
	end

	assign result_valid = result_valid_q;
	assign out_value    = out_value_q;
	assign run_last     = run_last_q;

endmodule
